### hw/rtl/jsts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsts_pkg
// Shared types and constants for the JSON string token scanner.
// ----------------------------------------------------------------------------
package jsts_pkg;

  // Width of the running byte offset; wraps at this many bits (8 to 32).
  localparam int unsigned OffsetBits = 16;
  localparam int unsigned ErrOffBits = 16;
  localparam int unsigned CapBits    = 9;
  localparam int unsigned CountBits  = 9;

  localparam logic [CapBits-1:0] CapReset   = 9'd64;
  localparam logic [7:0]         CtrlLimit  = 8'h20;

  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChBslash = 8'h5C;
  localparam logic [7:0] ChSlash = 8'h2F;
  localparam logic [7:0] ChLowN  = 8'h6E;
  localparam logic [7:0] ChLowT  = 8'h74;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChTab   = 8'h09;
  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;

  typedef enum logic [2:0] {
    ErrNone       = 3'd0,
    ErrExpected   = 3'd1,
    ErrUnterm     = 3'd2,
    ErrCtrlByte   = 3'd3,
    ErrBadEscape  = 3'd4,
    ErrTooLong    = 3'd5
  } err_code_e;

  typedef enum logic [2:0] {
    PhWait = 3'b001,
    PhStr  = 3'b010,
    PhEsc  = 3'b100
  } scan_phase_e;

  typedef struct packed {
    logic [7:0]            out_char;
    logic                  char_valid;
    logic                  string_done;
    err_code_e             error_code;
    logic [ErrOffBits-1:0] error_offset;
  } result_t;

  // Low 16 bits of an offset, zero-extended when the offset is narrower.
  function automatic logic [ErrOffBits-1:0] err_offset(input logic [OffsetBits-1:0] off);
    logic [OffsetBits+ErrOffBits-1:0] ext;
    ext = {{ErrOffBits{1'b0}}, off};
    return ext[ErrOffBits-1:0];
  endfunction

endpackage

### hw/rtl/jsts_text_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsts_text_if
// Valid/ready channel carrying one text byte or an end-of-text mark.
// ----------------------------------------------------------------------------
interface jsts_text_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       text_ended;

  modport source (output valid, output text_byte, output text_ended, input ready);
  modport sink   (input valid, input text_byte, input text_ended, output ready);
endinterface

### hw/rtl/jsts_result_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsts_result_if
// Valid/ready channel carrying one decoded character or end/error report.
// ----------------------------------------------------------------------------
interface jsts_result_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_char;
  logic        char_valid;
  logic        string_done;
  logic [2:0]  error_code;
  logic [15:0] error_offset;

  modport source (output valid, output out_char, output char_valid, output string_done,
                  output error_code, output error_offset, input ready);
  modport sink   (input valid, input out_char, input char_valid, input string_done,
                  input error_code, input error_offset, output ready);
endinterface

### hw/rtl/json_string_token_scanner_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_token_scanner_core
// Skips whitespace, decodes one quoted JSON string per token and reports
// characters, closing quotes and errors with byte offsets.
// ----------------------------------------------------------------------------
// Usage:
//   text_i   : one beat per text byte, or an end-of-text beat (text_ended=1)
//              which clears the byte offset and flags an open string.
//   result_o : zero or one beat per text beat - a decoded character, a
//              string_done beat on the closing quote, or an error beat
//              (string_done=1, error_code/error_offset set).
//   cfg_we_i/cfg_wdata_i : string_capacity, write only while idle.
// A result is registered and appears in the cycle after its text beat is taken.
// Throughput: one text beat per cycle unless held off as below; the decode
// is a single step between the scan state registers and the result register.
// text_i.ready is low only while a result is held and result_o.ready is low;
// the result register then holds its beat and no text is taken.
// Reset: waiting for an opening quote, offset and count zero, capacity 64,
// no result pending.
// ----------------------------------------------------------------------------
module json_string_token_scanner_core
  import jsts_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CapBits-1:0]  cfg_wdata_i,
  jsts_text_if.sink           text_i,
  jsts_result_if.source       result_o
);

  logic [CapBits-1:0]    capacity_q;
  scan_phase_e           phase_q, phase_d;
  logic [OffsetBits-1:0] byte_off_q, byte_off_d;
  logic [OffsetBits-1:0] quote_off_q, quote_off_d;
  logic [CountBits-1:0]  count_q, count_d;

  logic    out_valid_q, out_valid_d;
  result_t out_q;
  result_t res;
  logic    res_valid;
  logic    accept;

  logic [OffsetBits-1:0] next_off;
  logic [CountBits:0]    count_inc;
  logic                  too_long;
  logic [7:0]            esc_char;
  logic                  esc_ok;
  logic [7:0]            b;

  assign text_i.ready = !out_valid_q || result_o.ready;
  assign accept       = text_i.valid && text_i.ready;
  assign b            = text_i.text_byte;
  assign next_off     = byte_off_q + 1'b1;
  assign count_inc    = {1'b0, count_q} + 1'b1;
  assign too_long     = count_inc >= {1'b0, capacity_q};

  always_comb begin
    esc_ok   = 1'b1;
    esc_char = b;
    case (b)
      ChQuote, ChBslash, ChSlash: esc_char = b;
      ChLowN:                     esc_char = ChLf;
      ChLowT:                     esc_char = ChTab;
      default:                    esc_ok   = 1'b0;
    endcase
  end

  always_comb begin
    phase_d     = phase_q;
    byte_off_d  = next_off;
    quote_off_d = quote_off_q;
    count_d     = count_q;
    res_valid   = 1'b0;
    res         = '{out_char: 8'h00, char_valid: 1'b0, string_done: 1'b0,
                    error_code: ErrNone, error_offset: '0};

    if (text_i.text_ended) begin
      if (phase_q == PhStr || phase_q == PhEsc) begin
        res_valid        = 1'b1;
        res.string_done  = 1'b1;
        res.error_code   = ErrUnterm;
        res.error_offset = err_offset(quote_off_q);
      end
      phase_d    = PhWait;
      count_d    = '0;
      byte_off_d = '0;
    end else begin
      unique case (phase_q)
        PhStr, PhEsc: begin
          res_valid = 1'b1;
          if (phase_q == PhStr && b == ChQuote) begin
            phase_d         = PhWait;
            count_d         = '0;
            res.string_done = 1'b1;
          end else if (phase_q == PhStr && b < CtrlLimit) begin
            phase_d          = PhWait;
            count_d          = '0;
            res.string_done  = 1'b1;
            res.error_code   = ErrCtrlByte;
            res.error_offset = err_offset(byte_off_q);
          end else if (phase_q == PhStr && b == ChBslash) begin
            phase_d   = PhEsc;
            res_valid = 1'b0;
          end else if (phase_q == PhEsc && !esc_ok) begin
            phase_d          = PhWait;
            count_d          = '0;
            res.string_done  = 1'b1;
            res.error_code   = ErrBadEscape;
            res.error_offset = err_offset(byte_off_q);
          end else if (too_long) begin
            phase_d          = PhWait;
            count_d          = '0;
            res.string_done  = 1'b1;
            res.error_code   = ErrTooLong;
            res.error_offset = err_offset(quote_off_q);
          end else begin
            phase_d        = PhStr;
            count_d        = count_inc[CountBits-1:0];
            res.char_valid = 1'b1;
            res.out_char   = (phase_q == PhEsc) ? esc_char : b;
          end
        end
        default: begin
          // waiting for an opening quote; stray codes land here too
          phase_d = PhWait;
          if (b == ChQuote) begin
            quote_off_d = byte_off_q;
            count_d     = '0;
            phase_d     = PhStr;
          end else if (!(b == ChSpace || b == ChTab || b == ChLf || b == ChCr)) begin
            res_valid        = 1'b1;
            count_d          = '0;
            res.string_done  = 1'b1;
            res.error_code   = ErrExpected;
            res.error_offset = err_offset(byte_off_q);
          end
        end
      endcase
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = res_valid;
    end else if (result_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      capacity_q  <= CapReset;
      phase_q     <= PhWait;
      byte_off_q  <= '0;
      quote_off_q <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        capacity_q <= cfg_wdata_i;
      end
      if (accept) begin
        phase_q     <= phase_d;
        byte_off_q  <= byte_off_d;
        quote_off_q <= quote_off_d;
        count_q     <= count_d;
      end
      out_valid_q <= out_valid_d;
    end
  end

  // result beat payload
  always_ff @(posedge clk_i) begin
    if (accept && res_valid) begin
      out_q <= res;
    end
  end

  assign result_o.valid        = out_valid_q;
  assign result_o.out_char     = out_q.out_char;
  assign result_o.char_valid   = out_q.char_valid;
  assign result_o.string_done  = out_q.string_done;
  assign result_o.error_code   = out_q.error_code;
  assign result_o.error_offset = out_q.error_offset;

`ifndef SYNTHESIS
  a_err_ends_string: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.error_code != ErrNone) |-> (out_q.string_done && !out_q.char_valid))
    else $error("error beat without string_done");

  a_char_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_q.char_valid) |-> (!out_q.string_done && out_q.error_offset == '0))
    else $error("character beat flagged as end of string");

  a_end_clears_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && text_i.text_ended) |=> (byte_off_q == '0 && phase_q == PhWait && count_q == '0))
    else $error("end of text did not clear scan state");
`endif

endmodule

### test/json_string_token_scanner_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_token_scanner_core_tb
// Self-checking bench for the JSON string scanner. Text beats go in over a
// valid/ready channel. A behavioural scan model predicts each character,
// closing-quote and error beat. Results are checked in order as they leave
// the block. Covered: directed tokens and errors, capacity extremes, a long
// receiver hold-off, and random traffic under several idling mixes.
// ----------------------------------------------------------------------------
module json_string_token_scanner_core_tb;
  import jsts_pkg::*;

  localparam int unsigned CycleLimit = 1_000_000;
  localparam int unsigned HoldCycles = 300;
  localparam int unsigned MaxReports = 10;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_we_i;
  logic [CapBits-1:0] cfg_wdata_i;

  jsts_text_if   text_if ();
  jsts_result_if res_if ();

  json_string_token_scanner_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .text_i      (text_if),
    .result_o    (res_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // scan model state
  scan_phase_e           phase;
  logic [OffsetBits-1:0] byte_pos;
  logic [OffsetBits-1:0] quote_pos;
  logic [CountBits-1:0]  char_count;
  logic [CapBits-1:0]    capacity;

  result_t pending_results[$];

  logic [7:0] blanks[4]  = '{ChSpace, ChTab, ChLf, ChCr};
  logic [7:0] escapes[5] = '{ChQuote, ChBslash, ChSlash, ChLowN, ChLowT};

  int unsigned tx_idle_pct  = 0;
  int unsigned rx_stall_pct = 0;
  bit          hold_req     = 1'b0;
  int unsigned hold_left    = 0;

  int unsigned cycles         = 0;
  int unsigned mismatches     = 0;
  int unsigned beats_sent     = 0;
  int unsigned token_beats    = 0;
  int unsigned chars_seen     = 0;
  int unsigned strings_closed = 0;
  int unsigned errors_seen    = 0;

  // ---------------------------------------------------------------- model
  function automatic result_t scan_fail(err_code_e code, logic [OffsetBits-1:0] where);
    result_t r;
    r = '0;
    r.string_done  = 1'b1;
    r.error_code   = code;
    r.error_offset = ErrOffBits'(where);
    phase      = PhWait;
    char_count = '0;
    return r;
  endfunction

  function automatic result_t scan_emit(logic [7:0] ch);
    result_t r;
    r = '0;
    if (int'(char_count) + 1 >= int'(capacity)) begin
      byte_pos++;
      return scan_fail(ErrTooLong, quote_pos);
    end
    char_count++;
    byte_pos++;
    r.out_char   = ch;
    r.char_valid = 1'b1;
    r.error_code = ErrNone;
    return r;
  endfunction

  // Returns 1 when the beat produces a result.
  function automatic bit scan_beat(input logic [7:0] b, input logic ended, output result_t r);
    logic [OffsetBits-1:0] here;
    logic [7:0]            ch;
    bit                    has;
    here = byte_pos;
    r    = '0;
    r.error_code = ErrNone;
    if (ended) begin
      has = (phase == PhStr || phase == PhEsc);
      if (has) r = scan_fail(ErrUnterm, quote_pos);
      phase      = PhWait;
      char_count = '0;
      byte_pos   = '0;
      return has;
    end
    case (phase)
      PhStr: begin
        if (b == ChQuote) begin
          byte_pos++;
          phase         = PhWait;
          char_count    = '0;
          r.string_done = 1'b1;
          return 1'b1;
        end
        if (b < CtrlLimit) begin
          byte_pos++;
          r = scan_fail(ErrCtrlByte, here);
          return 1'b1;
        end
        if (b == ChBslash) begin
          byte_pos++;
          phase = PhEsc;
          return 1'b0;
        end
        r = scan_emit(b);
        return 1'b1;
      end
      PhEsc: begin
        if (b == ChQuote || b == ChBslash || b == ChSlash) ch = b;
        else if (b == ChLowN) ch = ChLf;
        else if (b == ChLowT) ch = ChTab;
        else begin
          byte_pos++;
          r = scan_fail(ErrBadEscape, here);
          return 1'b1;
        end
        phase = PhStr;
        r = scan_emit(ch);
        return 1'b1;
      end
      default: begin
        phase = PhWait;
        if (b == ChSpace || b == ChTab || b == ChLf || b == ChCr) begin
          byte_pos++;
          return 1'b0;
        end
        if (b == ChQuote) begin
          quote_pos  = here;
          char_count = '0;
          phase      = PhStr;
          byte_pos++;
          return 1'b0;
        end
        byte_pos++;
        r = scan_fail(ErrExpected, here);
        return 1'b1;
      end
    endcase
  endfunction

  // ------------------------------------------------------------- receiver
  task automatic check_beat();
    result_t got;
    result_t want;
    got.out_char     = res_if.out_char;
    got.char_valid   = res_if.char_valid;
    got.string_done  = res_if.string_done;
    got.error_code   = err_code_e'(res_if.error_code);
    got.error_offset = res_if.error_offset;
    if (got.char_valid === 1'b1) chars_seen++;
    if (got.string_done === 1'b1 && got.error_code == ErrNone) strings_closed++;
    if (got.error_code != ErrNone) errors_seen++;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: unexpected beat: char %02h cv %0b done %0b err %0d off %0d",
                 $time, got.out_char, got.char_valid, got.string_done, got.error_code,
                 got.error_offset);
      return;
    end
    want = pending_results.pop_front();
    if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
        got.string_done !== want.string_done || got.error_code !== want.error_code ||
        got.error_offset !== want.error_offset) begin
      mismatches++;
      if (mismatches <= MaxReports)
        $display("%0t: mismatch got %02h/%0b/%0b/%0d/%0d expected %02h/%0b/%0b/%0d/%0d",
                 $time, got.out_char, got.char_valid, got.string_done, got.error_code,
                 got.error_offset, want.out_char, want.char_valid, want.string_done,
                 want.error_code, want.error_offset);
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready) check_beat();
    res_if.ready <= !(hold_req || hold_left != 0) && ($urandom_range(99) >= rx_stall_pct);
  end

  // long receiver hold-off, counted here
  always @(posedge clk_i) begin
    if (hold_req) hold_left <= HoldCycles;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  // --------------------------------------------------------------- sender
  task automatic send_beat(input logic [7:0] b, input logic ended);
    result_t r;
    while ($urandom_range(99) < tx_idle_pct) begin
      text_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    text_if.valid      <= 1'b1;
    text_if.text_byte  <= b;
    text_if.text_ended <= ended;
    do @(posedge clk_i); while (!text_if.ready);
    if (scan_beat(b, ended, r)) pending_results.push_back(r);
    beats_sent++;
  endtask

  // wait for all results, plus a few cycles for a beat with no result
  task automatic settle();
    text_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_capacity(input logic [CapBits-1:0] value);
    settle();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    capacity = value;
  endtask

  function automatic logic [7:0] pick_plain_char();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 126)); while (b == ChQuote || b == ChBslash);
    return b;
  endfunction

  task automatic send_random_token();
    int unsigned roll;
    int unsigned len;
    logic [7:0]  b;
    roll = $urandom_range(99);
    if (roll < 10) begin
      repeat ($urandom_range(1, 4)) begin
        send_beat(8'($urandom), $urandom_range(15) == 0);
        token_beats++;
      end
      return;
    end
    repeat ($urandom_range(0, 2)) send_beat(blanks[$urandom_range(3)], 1'b0);
    send_beat(ChQuote, 1'b0);
    token_beats++;
    len = ($urandom_range(99) < 85) ? $urandom_range(0, 10)
                                     : $urandom_range(0, int'(capacity) + 2);
    repeat (len) begin
      roll = $urandom_range(99);
      if (roll < 70) send_beat(pick_plain_char(), 1'b0);
      else if (roll < 80) send_beat(8'($urandom_range(128, 255)), 1'b0);
      else begin
        send_beat(ChBslash, 1'b0);
        send_beat(escapes[$urandom_range(4)], 1'b0);
        token_beats++;
      end
      token_beats++;
    end
    roll = $urandom_range(99);
    if (roll < 80) send_beat(ChQuote, 1'b0);
    else if (roll < 85) send_beat(8'($urandom_range(0, 31)), 1'b0);
    else if (roll < 90) begin
      send_beat(ChBslash, 1'b0);
      token_beats++;
      do b = 8'($urandom); while (b inside {ChQuote, ChBslash, ChSlash, ChLowN, ChLowT});
      send_beat(b, 1'b0);
    end else if (roll < 95) send_beat(8'($urandom), 1'b1);
    else begin
      send_beat(ChBslash, 1'b0);
      token_beats++;
      send_beat(8'($urandom), 1'b1);
    end
    token_beats++;
  endtask

  // ---------------------------------------------------------------- tests
  task automatic test_tokens();
    // blanks, plain and high bytes, every escape
    foreach (blanks[i]) send_beat(blanks[i], 1'b0);
    send_beat(ChQuote, 1'b0);
    send_beat(8'h41, 1'b0);
    send_beat(ChSpace, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'hFF, 1'b0);
    foreach (escapes[i]) begin
      send_beat(ChBslash, 1'b0);
      send_beat(escapes[i], 1'b0);
    end
    send_beat(ChQuote, 1'b0);
  endtask

  task automatic test_errors();
    send_beat(8'h78, 1'b0);              // not a string
    send_beat(ChQuote, 1'b0);
    send_beat(8'h1F, 1'b0);              // raw control byte
    send_beat(ChQuote, 1'b0);
    send_beat(ChBslash, 1'b0);
    send_beat(8'h00, 1'b0);              // control byte after backslash
    send_beat(ChQuote, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(8'hA5, 1'b1);              // text ends inside string
    send_beat(ChQuote, 1'b0);
    send_beat(ChBslash, 1'b0);
    send_beat(8'h5A, 1'b1);              // text ends after backslash
    send_beat(8'h00, 1'b1);              // text ends while waiting
  endtask

  task automatic test_capacity_limits();
    write_capacity(9'd1);
    send_beat(ChQuote, 1'b0);
    send_beat(ChQuote, 1'b0);            // empty string still fits
    send_beat(ChQuote, 1'b0);
    send_beat(8'h61, 1'b0);
    write_capacity(9'd2);
    send_beat(ChQuote, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(ChQuote, 1'b0);
    send_beat(ChQuote, 1'b0);
    send_beat(8'h61, 1'b0);
    send_beat(ChBslash, 1'b0);
    send_beat(ChLowN, 1'b0);             // escape overflows too
    write_capacity(9'd256);
    send_beat(ChQuote, 1'b0);
    repeat (255) send_beat(pick_plain_char(), 1'b0);
    send_beat(ChQuote, 1'b0);
    send_beat(ChQuote, 1'b0);
    repeat (256) send_beat(pick_plain_char(), 1'b0);
  endtask

  task automatic test_backpressure();
    write_capacity(9'd128);
    hold_req <= 1'b1;
    @(posedge clk_i);
    hold_req <= 1'b0;
    send_beat(ChQuote, 1'b0);
    repeat (40) send_beat(pick_plain_char(), 1'b0);
    send_beat(ChQuote, 1'b0);
    settle();
    send_beat(ChQuote, 1'b0);
    send_beat(8'h62, 1'b0);
    send_beat(ChQuote, 1'b0);
  endtask

  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input logic [CapBits-1:0] cap, input int unsigned n);
    int unsigned target;
    write_capacity(cap);
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    target = token_beats + n;
    while (token_beats < target) send_random_token();
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
  endtask

  initial begin
    rst_ni             = 1'b0;
    cfg_we_i           = 1'b0;
    cfg_wdata_i        = '0;
    text_if.valid      = 1'b0;
    text_if.text_byte  = '0;
    text_if.text_ended = 1'b0;
    res_if.ready       = 1'b0;
    phase      = PhWait;
    byte_pos   = '0;
    quote_pos  = '0;
    char_count = '0;
    capacity   = CapReset;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_tokens();
    test_errors();
    test_capacity_limits();
    test_backpressure();
    test_random_traffic(0, 0, 9'd64, 270);
    test_random_traffic(53, 0, 9'd8, 270);
    test_random_traffic(0, 53, 9'd256, 270);
    test_random_traffic(7, 7, 9'($urandom_range(1, 256)), 270);

    text_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (5) @(posedge clk_i);

    $display("Sent %0d text beats over capacities 1 to 256, a long hold-off and idling mixes",
             beats_sent);
    $display("Results: %0d chars, %0d strings closed, %0d error reports, %0d mismatches",
             chars_seen, strings_closed, errors_seen, mismatches);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
